>>> rtl/bid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bid_pkg: shared types and constants for the bounded identifier set
// Field widths, operation codes, controller states and the control
// bundle that the controller broadcasts to the entry cells.
// ----------------------------------------------------------------------------
package bid_pkg;

  // Fixed field widths
  localparam int IdW    = 32;
  localparam int OpW    = 2;
  localparam int CountW = 8;

  // Default number of entry cells (1 to 255, the count field is 8 bits)
  localparam int DefCapacity = 255;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  // Broadcast to every cell during the apply cycle
  typedef struct packed {
    logic add_go;     // append the held key at the first free cell
    logic remove_go;  // close the gap at the matching cell
  } cell_ctl_t;

endpackage

>>> rtl/bid_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bid_if: request and response channels of the bounded identifier set
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bid_req_if;
  logic                        valid;
  logic                        ready;
  logic [bid_pkg::OpW-1:0]     operation;
  logic [bid_pkg::IdW-1:0]     member_id;

  modport source (output valid, output operation, output member_id, input ready);
  modport sink   (input valid, input operation, input member_id, output ready);
endinterface

interface bid_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [bid_pkg::CountW-1:0]  entry_count;

  modport source (output valid, output success, output entry_count, input ready);
  modport sink   (input valid, input success, input entry_count, output ready);
endinterface

>>> rtl/bid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bid_cell: one entry of the identifier list
// Holds one identifier and its valid bit, registers a compare against the
// incoming key, and on a remove takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module bid_cell
  import bid_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  cell_ctl_t      ctl,
  input  logic           cap_en,      // request beat accepted this cycle
  input  logic [IdW-1:0] cmp_key,     // key of the beat being accepted
  input  logic [IdW-1:0] wr_key,      // key held for the apply cycle
  input  logic           valid_left,
  input  logic           valid_right,
  input  logic [IdW-1:0] data_right,
  input  logic           hit_upto,    // a match sits here or further left
  output logic [IdW-1:0] data,
  output logic           valid,
  output logic           match
);

  logic shift_en;
  logic append_en;

  assign shift_en  = ctl.remove_go & hit_upto;
  assign append_en = ctl.add_go & valid_left & ~valid;

  // Control: valid bit and registered compare
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (cap_en) begin
        match <= valid && (data == cmp_key);
      end
      if (shift_en) begin
        valid <= valid_right;
      end else if (append_en) begin
        valid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= data_right;
    end else if (append_en) begin
      data <= wr_key;
    end
  end

endmodule

>>> rtl/bid_prefix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bid_prefix: prefix OR over the cell match bits
// Log-depth parallel-prefix network; bit i is set when any cell at or left
// of i matched. The top bit is the overall hit.
// ----------------------------------------------------------------------------
module bid_prefix #(
  parameter int N = 255
) (
  input  logic [N-1:0] hits,
  output logic [N-1:0] upto
);

  localparam int Levels = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [0:Levels];

  always_comb begin
    lvl[0] = hits;
    for (int k = 0; k < Levels; k++) begin
      for (int i = 0; i < N; i++) begin
        if (i >= (1 << k)) begin
          lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
        end else begin
          lvl[k+1][i] = lvl[k][i];
        end
      end
    end
  end

  assign upto = lvl[Levels];

endmodule

>>> rtl/bounded_id_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_id_set: ordered set of up to CAPACITY distinct 32-bit identifiers
// Add appends an absent identifier when there is room, remove deletes a
// present one and closes the gap, query reports membership. One response
// beat per request: success flag and the count after the operation.
// ----------------------------------------------------------------------------
// Each request runs as follows: at the accepting edge each entry cell
// registers its compare against the key, and in the following apply cycle
// a prefix OR over the match bits decides the hit and drives the remove
// shift or the append in the cells, with the response registered at its
// end. One request is in work at a time; the next one is accepted in the
// cycle after the response is registered, even while that response still
// waits. The apply cycle holds while an earlier response is not taken.
// No clearing pass: reset clears every cell's valid bit at once.
// ----------------------------------------------------------------------------
module bounded_id_set
  import bid_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input  logic     clk,
  input  logic     rst,
  bid_req_if.sink   req,
  bid_rsp_if.source rsp
);

  state_t state;
  state_t state_next;

  logic              req_fire;
  logic              apply_go;
  op_t               op_q;
  logic [IdW-1:0]    key_q;
  logic [CountW-1:0] held_count;

  logic                rsp_valid;
  logic                rsp_success;
  logic [CountW-1:0]   rsp_count;

  logic [IdW-1:0]      cell_data  [0:CAPACITY-1];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] hit_upto;

  logic      present;
  logic      full;
  logic      add_ok;
  logic      rem_ok;
  logic      ok;
  cell_ctl_t ctl;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_fire) state_next = S_APPLY;
      S_APPLY: if (apply_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    req.ready = 1'b0;
    apply_go  = 1'b0;
    case (state)
      S_IDLE:  req.ready = 1'b1;
      S_APPLY: apply_go  = ~rsp_valid | rsp.ready;
      default: ;
    endcase
  end

  assign req_fire = req.valid & req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request for the apply cycle
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q  <= op_t'(req.operation);
      key_q <= req.member_id;
    end
  end

  // Hit and decision
  bid_prefix #(.N(CAPACITY)) u_prefix (
    .hits (cell_match),
    .upto (hit_upto)
  );

  assign present = hit_upto[CAPACITY-1];
  assign full    = cell_valid[CAPACITY-1];

  always_comb begin
    add_ok = 1'b0;
    rem_ok = 1'b0;
    ok     = 1'b0;
    case (op_q)
      OP_ADD: begin
        add_ok = ~present & ~full;
        ok     = add_ok;
      end
      OP_REMOVE: begin
        rem_ok = present;
        ok     = present;
      end
      OP_QUERY: ok = present;
      default: ;
    endcase
  end

  assign ctl.add_go    = apply_go & add_ok;
  assign ctl.remove_go = apply_go & rem_ok;

  // Entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic           vl;
    logic           vr;
    logic [IdW-1:0] dr;

    if (i == 0) begin : g_first
      assign vl = 1'b1;
    end else begin : g_mid
      assign vl = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign vr = 1'b0;
      assign dr = '0;
    end else begin : g_inner
      assign vr = cell_valid[i+1];
      assign dr = cell_data[i+1];
    end

    bid_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .cap_en      (req_fire),
      .cmp_key     (req.member_id),
      .wr_key      (key_q),
      .valid_left  (vl),
      .valid_right (vr),
      .data_right  (dr),
      .hit_upto    (hit_upto[i]),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .match       (cell_match[i])
    );
  end

  // Count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (apply_go) begin
        rsp_valid <= 1'b1;
        if (ctl.add_go) begin
          held_count <= held_count + CountW'(1);
        end else if (ctl.remove_go) begin
          held_count <= held_count - CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp_success <= ok;
      if (ctl.add_go) begin
        rsp_count <= held_count + CountW'(1);
      end else if (ctl.remove_go) begin
        rsp_count <= held_count - CountW'(1);
      end else begin
        rsp_count <= held_count;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.success     = rsp_success;
  assign rsp.entry_count = rsp_count;

  // Checks
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(held_count))
    else $error("held count differs from number of valid cells");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_match))
    else $error("identifier matched in more than one cell");

  a_rsp_after_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_APPLY))
    else $error("response raised outside the apply cycle");

endmodule

>>> bench/tb_bounded_id_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_id_set: self-checking bench for the bounded identifier set
// Drives add, remove, query and unused-code requests through the request
// channel and checks every response beat against a queue-based membership
// model kept in the bench. A short directed table comes first. Random
// phases follow: fill to capacity, hammer the full list, drain to empty,
// then mixed churn. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_bounded_id_set;
  import bid_pkg::*;

  localparam int Capacity   = DefCapacity;
  localparam int RandItems  = 1050;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 10;

  // Operation code that the block must treat as a no-op
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic              success;
    logic [CountW-1:0] entry_count;
  } membership_result_t;

  typedef struct {
    logic [OpW-1:0]    op;
    logic [IdW-1:0]    id;
    bit                pinned;  // 1: expected value typed in below
    logic              ok;
    logic [CountW-1:0] cnt;
  } directed_row_t;

  localparam int DirRows = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bid_req_if req_ch ();
  bid_rsp_if rsp_ch ();

  // Typed-in expectation that travels with the request beat
  logic              pin_on  = 1'b0;
  logic              pin_ok  = 1'b0;
  logic [CountW-1:0] pin_cnt = '0;

  logic [IdW-1:0]     held_ids[$];          // bench copy of the list, oldest first
  membership_result_t expected_results[$];
  int                 errors      = 0;
  int                 cycle_count = 0;
  int                 burst_left  = 0;
  int                 rand_sent   = 0;

  // Directed table: empty list, all-zero and all-one ids, duplicates,
  // unused code, removal at head, middle and tail
  directed_row_t directed_rows [DirRows] = '{
    '{OP_QUERY,  32'h0000_0000, 1'b1, 1'b0, 8'd0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0},
    '{OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 8'd1},
    '{OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 8'd2},
    '{OP_ADD,    32'h0000_0000, 1'b1, 1'b0, 8'd2},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b1, 1'b1, 8'd2},
    '{OP_ADD,    32'h8000_0000, 1'b0, 1'b0, 8'd0},
    '{OP_ADD,    32'h0000_0001, 1'b0, 1'b0, 8'd0},
    '{OpUnused,  32'h0000_0000, 1'b1, 1'b0, 8'd4},
    '{OpUnused,  32'hFFFF_FFFF, 1'b1, 1'b0, 8'd4},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,  32'h8000_0000, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
    '{OP_ADD,    32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,  32'h0000_0001, 1'b0, 1'b0, 8'd0},
    '{OP_ADD,    32'hA5A5_A5A5, 1'b0, 1'b0, 8'd0},
    '{OP_ADD,    32'h5A5A_5A5A, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,  32'h5A5A_5A5A, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'h8000_0000, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'h0000_0001, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'hA5A5_A5A5, 1'b0, 1'b0, 8'd0},
    '{OP_REMOVE, 32'h5A5A_5A5A, 1'b1, 1'b1, 8'd0}
  };

  bounded_id_set #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Membership model: apply one request, return flag and count after it
  function automatic void apply_membership_op(input logic [OpW-1:0] op,
                                              input logic [IdW-1:0] id,
                                              output logic ok,
                                              output logic [CountW-1:0] cnt);
    int pos;
    pos = -1;
    foreach (held_ids[i])
      if (pos < 0 && held_ids[i] == id) pos = i;
    ok = 1'b0;
    case (op)
      OP_ADD: begin
        if (pos < 0 && held_ids.size() < Capacity) begin
          held_ids.push_back(id);
          ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          held_ids.delete(pos);  // later entries close the gap
          ok = 1'b1;
        end
      end
      OP_QUERY: ok = (pos >= 0);
      default: ok = 1'b0;
    endcase
    cnt = CountW'(held_ids.size());
  endfunction

  // Either an id currently held (any position) or a fresh random one
  function automatic logic [IdW-1:0] pick_id(input bit from_held);
    if (from_held && held_ids.size() > 0)
      return held_ids[$urandom_range(0, held_ids.size() - 1)];
    return $urandom();
  endfunction

  // Sender bursts with random gaps; entered and left at the falling edge
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Offer one request beat and hold it until accepted
  task automatic send_request(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                              input bit pinned, input logic exp_ok,
                              input logic [CountW-1:0] exp_cnt);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.member_id <= id;
    pin_on           <= pinned;
    pin_ok           <= exp_ok;
    pin_cnt          <= exp_cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_step(input int add_pct, input int rem_pct, input int qry_pct);
    int             roll;
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      op = OP_ADD;
      id = pick_id($urandom_range(0, 99) < 15);
    end else if (roll < add_pct + rem_pct) begin
      op = OP_REMOVE;
      id = pick_id($urandom_range(0, 99) < 88);
    end else if (roll < add_pct + rem_pct + qry_pct) begin
      op = OP_QUERY;
      id = pick_id($urandom_range(0, 1) == 1);
    end else begin
      op = OpUnused;
      id = pick_id($urandom_range(0, 1) == 1);
    end
    pace();
    send_request(op, id, 1'b0, 1'b0, '0);
    rand_sent++;
  endtask

  // Stop offering and let every outstanding response come back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Checker: response beats against the oldest expectation, request beats
  // into the model
  always @(posedge clk) begin
    logic               ok;
    logic [CountW-1:0]  cnt;
    membership_result_t want;
    cycle_count++;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected response beat: success %0d entry_count %0d",
                   $time, rsp_ch.success, rsp_ch.entry_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.success !== want.success) begin
            $display("%0t: success mismatch: expected %0d, got %0d",
                     $time, want.success, rsp_ch.success);
            errors++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, got %0d",
                     $time, want.entry_count, rsp_ch.entry_count);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        apply_membership_op(req_ch.operation, req_ch.member_id, ok, cnt);
        if (pin_on) expected_results.push_back('{pin_ok, pin_cnt});
        else        expected_results.push_back('{ok, cnt});
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: long hold-off first so the block backs up, then a mix of
  // open stretches, random stalls and occasional long hold-offs
  initial begin
    int mode;
    int span;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    repeat (60) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 15);
      span = $urandom_range(8, 40);
      if (mode == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(40, 90)) @(negedge clk);
      end else if (mode < 6) begin
        rsp_ch.ready <= 1'b1;
        repeat (span) @(negedge clk);
      end else begin
        repeat (span) begin
          rsp_ch.ready <= ($urandom_range(0, 2) != 0);
          @(negedge clk);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_ADD;
    req_ch.member_id = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[r]) begin
      pace();
      send_request(directed_rows[r].op, directed_rows[r].id, directed_rows[r].pinned,
                   directed_rows[r].ok, directed_rows[r].cnt);
    end
    settle();

    // Fill to capacity, then keep pushing at a full list
    while (held_ids.size() < Capacity) random_step(75, 8, 12);
    repeat (40) random_step(60, 10, 20);
    settle();

    // Drain to empty
    while (held_ids.size() > 0) random_step(10, 75, 10);
    settle();

    // Mixed churn at small sizes
    while (rand_sent < RandItems) random_step(45, 35, 15);

    settle();
    repeat (DrainWait) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
